@@ design/tq_pkg.sv @@
package tq_pkg;

  // operation codes on the cmd input
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // configuration register word indexes
  localparam logic REG_SORT_MODE = 1'b0;

  // controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EXEC = 4'b1000
  } tq_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic pos_clear;
    logic pos_load_tail;
    logic pos_inc;
    logic cmp_load;
    logic exec;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic scan_stop;
  } dp_status_t;

endpackage

@@ design/tq_ctrl.sv @@
module tq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               cmd,
  input  logic               sort_mode,
  input  tq_pkg::dp_status_t stat,
  output tq_pkg::ctrl_cmd_t  ctl,
  output logic               busy
);
  import tq_pkg::*;

  tq_state_t state;
  tq_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load_req = 1'b1;
          if (cmd == CMD_DEQ || stat.full) begin
            state_next = S_EXEC;
          end else if (!sort_mode) begin
            ctl.pos_load_tail = 1'b1;
            state_next        = S_EXEC;
          end else begin
            ctl.pos_clear = 1'b1;
            state_next    = S_CMP;
          end
        end
      end
      S_CMP: begin
        ctl.cmp_load = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_stop) begin
          state_next = S_EXEC;
        end else begin
          ctl.pos_inc = 1'b1;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/tq_dp.sv @@
module tq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  tq_pkg::ctrl_cmd_t  ctl,
  input  logic               cmd,
  input  logic [7:0]         thread_id,
  input  logic [63:0]        run_time,
  output tq_pkg::dp_status_t stat,
  output logic               done,
  output logic [1:0]         status,
  output logic [7:0]         out_thread_id,
  output logic [63:0]        out_run_time,
  output logic               now_empty
);
  import tq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  // latched request
  logic               req_cmd;
  logic [ID_BITS-1:0] req_id;
  logic [63:0]        req_time;

  // slot cells, head at index 0
  logic [ID_BITS-1:0] slot_id   [QUEUE_DEPTH];
  logic [63:0]        slot_time [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] gt_flag;
  logic [CNT_W-1:0]       fill;
  logic [CNT_W-1:0]       pos;
  logic                   full;
  logic                   empty;

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);

  // scan ends at the tail or at the first slot not below the new time
  assign stat.full      = full;
  assign stat.scan_stop = (pos == fill) || !gt_flag[pos[IDX_W-1:0]];

  // request latch, insert position and per-cell compare flags
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_cmd  <= cmd;
      req_id   <= ID_BITS'(thread_id);
      req_time <= run_time;
    end
    if (ctl.pos_clear) begin
      pos <= '0;
    end else if (ctl.pos_load_tail) begin
      pos <= fill;
    end else if (ctl.pos_inc) begin
      pos <= pos + CNT_W'(1);
    end
    if (ctl.cmp_load) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        gt_flag[i] <= (req_time > slot_time[i]);
      end
    end
  end

  // slot cells: shift toward head on removal, open a gap on insert
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (req_cmd == CMD_DEQ) begin
        if (!empty) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            slot_id[i]   <= slot_id[i+1];
            slot_time[i] <= slot_time[i+1];
          end
        end
      end else if (!full) begin
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (CNT_W'(i) > pos) begin
            slot_id[i]   <= slot_id[i-1];
            slot_time[i] <= slot_time[i-1];
          end
        end
        slot_id[pos[IDX_W-1:0]]   <= req_id;
        slot_time[pos[IDX_W-1:0]] <= req_time;
      end
    end
  end

  // fill count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= ctl.exec;
      if (ctl.exec) begin
        if (req_cmd == CMD_DEQ) begin
          if (!empty) begin
            fill <= fill - CNT_W'(1);
          end
        end else if (!full) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if (req_cmd == CMD_DEQ && !empty) begin
        out_thread_id <= 8'(slot_id[0]);
        out_run_time  <= slot_time[0];
      end else begin
        out_thread_id <= '0;
        out_run_time  <= '0;
      end
      if (req_cmd == CMD_DEQ) begin
        if (empty) begin
          status    <= ST_EMPTY;
          now_empty <= 1'b1;
        end else begin
          status    <= ST_OK;
          now_empty <= (fill == CNT_W'(1));
        end
      end else begin
        status    <= full ? ST_FULL : ST_OK;
        now_empty <= 1'b0;
      end
    end
  end

endmodule

@@ design/thread_ready_queue.sv @@
// channel   | direction | signals                                  | handshake
// ----------+-----------+------------------------------------------+------------------------
// request   | in        | cmd, thread_id, run_time                 | start & !busy
// result    | out       | status, out_thread_id, out_run_time,     | done, one cycle
//           |           | now_empty                                |
// config    | in        | psel, penable, pwrite, paddr, pwdata,    | psel & penable & pwrite
//           |           | prdata, pready                           |
//
// dequeue, fifo enqueue and rejected enqueue: idle then exec state; the result strobe is
// registered at the same edge as the queue update.
// sorted enqueue: idle, compare, scan and exec states in order; the scan
// counter walks the registered per-slot compare flags one slot a cycle.
// rst is synchronous: queue empty, sort_mode 0, no result pending.
// done is never held off; the next request may start in the cycle done is high.
module thread_ready_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  thread_id,
  input  logic [63:0] run_time,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  out_thread_id,
  output logic [63:0] out_run_time,
  output logic        now_empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tq_pkg::*;

  logic       sort_mode;
  ctrl_cmd_t  ctl;
  dp_status_t stat;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SORT_MODE) begin
      sort_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SORT_MODE) begin
      prdata[0] = sort_mode;
    end
  end

  // controller
  tq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .sort_mode (sort_mode),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy)
  );

  // datapath
  tq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd           (cmd),
    .thread_id     (thread_id),
    .run_time      (run_time),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .out_thread_id (out_thread_id),
    .out_run_time  (out_run_time),
    .now_empty     (now_empty)
  );

  // a result is given only once the controller is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always occupies the controller next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but controller idle");

  // rejected dequeue reports an empty queue and no entry
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (now_empty && out_thread_id == 8'd0))
    else $error("empty dequeue result malformed");

  // a full queue can never be reported empty
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> !now_empty)
    else $error("full enqueue result reports empty");

endmodule
